// ----- rtl/rdd_pkg.sv -----
`default_nettype none
package rdd_pkg;

  localparam int DEPTH_DEF       = 64;
  localparam int VALUE_WIDTH_DEF = 16;
  localparam int VALUE_BITS      = 16;
  localparam int CMD_BITS        = 2;
  localparam int RES_QUEUE_DEPTH = 4;

  typedef enum logic [CMD_BITS-1:0] {
    CMD_LOAD    = 2'd0,
    CMD_REVERSE = 2'd1,
    CMD_DISCARD = 2'd2,
    CMD_DRAIN   = 2'd3
  } cmd_t;

  typedef enum logic {
    ST_IDLE  = 1'b0,
    ST_DRAIN = 1'b1
  } state_t;

  typedef struct packed {
    logic                  empty_res;
    logic                  error;
    logic                  last;
    logic [VALUE_BITS-1:0] value;
  } result_t;

endpackage
`default_nettype wire

// ----- rtl/rdd_ram.sv -----
`default_nettype none
module rdd_ram
  import rdd_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEF,
  parameter int WIDTH = VALUE_WIDTH_DEF,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             wr_en,
  input  wire logic [AW-1:0]    wr_addr,
  input  wire logic [WIDTH-1:0] wr_data,
  input  wire logic             rd_en,
  input  wire logic [AW-1:0]    rd_addr,
  output logic      [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
`default_nettype wire

// ----- rtl/reversible_deque_discard_unit.sv -----
`default_nettype none
// Reversible deque with discard.
// The input channel carries one command per beat: in_tuser holds the command
// (load, reverse, discard, drain) and in_tdata holds the value for a load.
// Load, reverse and discard produce no result beat.
// A drain reads the stored elements out of the element RAM in the current
// direction, one per cycle while the result queue has room, and sends them
// on the output channel with out_tlast on the final beat; out_tuser flags an
// error drain or an empty drain, each of which produces a single beat. The
// first drained beat passes the drain state, the registered RAM read and the
// result queue before it appears. The input channel is held off while the
// RAM reads are issued and while the last read returns.
// Results pass through a four-entry result queue, so commands keep being
// accepted while results wait. When the receiver stalls, the queue fills and
// RAM reads pause, then input is held off until space frees up.
// A synchronous reset clears pointers, count, direction, error and the
// queue; RAM contents are not cleared and no clearing pass is needed.
module reversible_deque_discard_unit
  import rdd_pkg::*;
#(
  parameter int DEPTH       = DEPTH_DEF,
  parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [15:0] in_tdata,   // [15:0] value
  input  wire logic [1:0]  in_tuser,   // [1:0] cmd
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic      [15:0] out_tdata,  // [15:0] value_res
  output logic             out_tlast,  // last
  output logic      [1:0]  out_tuser   // [0] error, [1] empty_res
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam int QW = $clog2(RES_QUEUE_DEPTH);
  localparam int QC = $clog2(RES_QUEUE_DEPTH + 1);

  function automatic logic [PW-1:0] wrap_add(input logic [PW-1:0] a, input logic [PW-1:0] b);
    logic [PW:0] sum;
    sum = {1'b0, a} + {1'b0, b};
    if (sum >= (PW+1)'(DEPTH)) begin
      sum = sum - (PW+1)'(DEPTH);
    end
    return sum[PW-1:0];
  endfunction

  state_t           state_r, state_nxt;
  logic [PW-1:0]    head_r, head_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic             rev_r, rev_nxt;
  logic             err_r, err_nxt;
  logic [PW-1:0]    dr_ptr_r, dr_ptr_nxt;
  logic [CW-1:0]    dr_rem_r, dr_rem_nxt;
  logic             dr_rev_r, dr_rev_nxt;
  logic             pend_r, pend_nxt;
  logic             pend_last_r, pend_last_nxt;

  result_t          q_mem_r [RES_QUEUE_DEPTH];
  logic [QW-1:0]    q_wr_r, q_rd_r;
  logic [QC-1:0]    q_cnt_r;

  logic             in_fire;
  cmd_t             cmd;
  logic             push;
  result_t          push_data;
  logic             pop;
  logic             wr_en;
  logic [PW-1:0]    wr_addr;
  logic [VALUE_WIDTH-1:0] wr_data;
  logic             rd_en;
  logic [VALUE_WIDTH-1:0] rd_data;

  assign cmd       = cmd_t'(in_tuser);
  assign in_tready = (state_r == ST_IDLE) && !pend_r && (q_cnt_r < QC'(RES_QUEUE_DEPTH));
  assign in_fire   = in_tvalid && in_tready;
  assign wr_data   = VALUE_WIDTH'(in_tdata);
  assign wr_addr   = wrap_add(head_r, cnt_r[PW-1:0]);

  always_comb begin
    state_nxt     = state_r;
    head_nxt      = head_r;
    cnt_nxt       = cnt_r;
    rev_nxt       = rev_r;
    err_nxt       = err_r;
    dr_ptr_nxt    = dr_ptr_r;
    dr_rem_nxt    = dr_rem_r;
    dr_rev_nxt    = dr_rev_r;
    pend_nxt      = 1'b0;
    pend_last_nxt = pend_last_r;
    wr_en         = 1'b0;
    rd_en         = 1'b0;
    push          = 1'b0;
    push_data     = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          if (cmd == CMD_DRAIN) begin
            if (err_r) begin
              push            = 1'b1;
              push_data.error = 1'b1;
              push_data.last  = 1'b1;
            end else if (cnt_r == '0) begin
              push                = 1'b1;
              push_data.empty_res = 1'b1;
              push_data.last      = 1'b1;
            end else begin
              state_nxt  = ST_DRAIN;
              dr_ptr_nxt = rev_r ? wrap_add(head_r, PW'(cnt_r - CW'(1))) : head_r;
              dr_rem_nxt = cnt_r;
              dr_rev_nxt = rev_r;
            end
            head_nxt = '0;
            cnt_nxt  = '0;
            rev_nxt  = 1'b0;
            err_nxt  = 1'b0;
          end else if (!err_r) begin
            case (cmd)
              CMD_LOAD: begin
                if (cnt_r < CW'(DEPTH)) begin
                  wr_en   = 1'b1;
                  cnt_nxt = cnt_r + CW'(1);
                end
              end
              CMD_REVERSE: begin
                rev_nxt = !rev_r;
              end
              default: begin
                if (cnt_r == '0) begin
                  err_nxt = 1'b1;
                end else begin
                  if (!rev_r) begin
                    head_nxt = wrap_add(head_r, PW'(1));
                  end
                  cnt_nxt = cnt_r - CW'(1);
                end
              end
            endcase
          end
        end
      end
      ST_DRAIN: begin
        if ((q_cnt_r + QC'(pend_r)) < QC'(RES_QUEUE_DEPTH)) begin
          rd_en         = 1'b1;
          pend_nxt      = 1'b1;
          pend_last_nxt = (dr_rem_r == CW'(1));
          dr_rem_nxt    = dr_rem_r - CW'(1);
          if (dr_rev_r) begin
            dr_ptr_nxt = (dr_ptr_r == '0) ? PW'(DEPTH - 1) : dr_ptr_r - PW'(1);
          end else begin
            dr_ptr_nxt = wrap_add(dr_ptr_r, PW'(1));
          end
          if (dr_rem_r == CW'(1)) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
    if (pend_r) begin
      push            = 1'b1;
      push_data       = '0;
      push_data.last  = pend_last_r;
      push_data.value = VALUE_BITS'(rd_data);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      head_r      <= '0;
      cnt_r       <= '0;
      rev_r       <= 1'b0;
      err_r       <= 1'b0;
      dr_rem_r    <= '0;
      dr_rev_r    <= 1'b0;
      pend_r      <= 1'b0;
      pend_last_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      cnt_r       <= cnt_nxt;
      rev_r       <= rev_nxt;
      err_r       <= err_nxt;
      dr_rem_r    <= dr_rem_nxt;
      dr_rev_r    <= dr_rev_nxt;
      pend_r      <= pend_nxt;
      pend_last_r <= pend_last_nxt;
    end
  end

  always_ff @(posedge clk) begin
    dr_ptr_r <= dr_ptr_nxt;
  end

  rdd_ram #(
    .DEPTH (DEPTH),
    .WIDTH (VALUE_WIDTH)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (dr_ptr_r),
    .rd_data (rd_data)
  );

  assign out_tvalid = (q_cnt_r != '0);
  assign pop        = out_tvalid && out_tready;
  assign out_tdata  = q_mem_r[q_rd_r].value;
  assign out_tlast  = q_mem_r[q_rd_r].last;
  assign out_tuser  = {q_mem_r[q_rd_r].empty_res, q_mem_r[q_rd_r].error};

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem_r[q_wr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_wr_r  <= '0;
      q_rd_r  <= '0;
      q_cnt_r <= '0;
    end else begin
      if (push) begin
        q_wr_r <= q_wr_r + QW'(1);
      end
      if (pop) begin
        q_rd_r <= q_rd_r + QW'(1);
      end
      q_cnt_r <= q_cnt_r + QC'(push) - QC'(pop);
    end
  end

endmodule
`default_nettype wire

// ----- tb/tb_reversible_deque_discard_unit.sv -----
module tb_reversible_deque_discard_unit;
  import rdd_pkg::*;

  localparam int SLOTS    = DEPTH_DEF;
  localparam int PTR_BITS = $clog2(DEPTH_DEF);

  typedef enum int {
    SESS_CLEAN,
    SESS_UNDERRUN,
    SESS_NOISE,
    SESS_FILL
  } session_t;

  typedef struct {
    cmd_t        cmd;
    logic [15:0] value;
  } command_t;

  typedef struct {
    logic [15:0] value;
    logic        last;
    logic        error;
    logic        empty;
  } drain_beat_t;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [15:0] in_tdata   = '0;
  logic [1:0]  in_tuser   = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [15:0] out_tdata;
  logic        out_tlast;
  logic [1:0]  out_tuser;

  command_t    pending[$];
  drain_beat_t drain_beats[$];

  logic [15:0]         deque_mem [SLOTS];
  logic [PTR_BITS-1:0] deque_head  = '0;
  logic [PTR_BITS:0]   deque_count = '0;
  bit                  deque_rev   = 1'b0;
  bit                  deque_err   = 1'b0;

  bit idling  = 1'b1;
  bit in_took = 1'b0;
  int in_gap, out_gap, in_calm, out_calm;
  int queued_cmds, accepted_cmds, beats_checked, mismatches;
  int drains_seen, error_drains, empty_drains, dropped_loads;

  reversible_deque_discard_unit u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

  always #1 clk = ~clk;

  function automatic void apply_command(command_t c);
    logic [PTR_BITS-1:0] pos;
    drain_beat_t         b;
    if (c.cmd == CMD_DRAIN) begin
      drains_seen++;
      if (deque_err) begin
        b = '{16'h0000, 1'b1, 1'b1, 1'b0};
        drain_beats.insert(drain_beats.size(), b);
        error_drains++;
      end else if (deque_count == 0) begin
        b = '{16'h0000, 1'b1, 1'b0, 1'b1};
        drain_beats.insert(drain_beats.size(), b);
        empty_drains++;
      end else begin
        for (int i = 0; i < deque_count; i++) begin
          pos = PTR_BITS'(int'(deque_head) + (deque_rev ? int'(deque_count) - 1 - i : i));
          b = '{deque_mem[pos], (i + 1 == deque_count), 1'b0, 1'b0};
          drain_beats.insert(drain_beats.size(), b);
        end
      end
      deque_head  = '0;
      deque_count = '0;
      deque_rev   = 1'b0;
      deque_err   = 1'b0;
    end else if (!deque_err) begin
      case (c.cmd)
        CMD_LOAD: begin
          if (deque_count < SLOTS) begin
            deque_mem[PTR_BITS'(deque_head + deque_count)] = c.value;
            deque_count++;
          end else begin
            dropped_loads++;
          end
        end
        CMD_REVERSE: begin
          deque_rev = ~deque_rev;
        end
        default: begin
          if (deque_count == 0) begin
            deque_err = 1'b1;
          end else begin
            if (!deque_rev) deque_head++;
            deque_count--;
          end
        end
      endcase
    end
  endfunction

  always @(posedge clk) begin
    command_t    c;
    drain_beat_t want;
    if (rst_n) begin
      in_took = in_tvalid && in_tready;
      if (in_took) begin
        accepted_cmds++;
        c.cmd   = cmd_t'(in_tuser);
        c.value = in_tdata;
        apply_command(c);
      end
      if (out_tvalid && out_tready) begin
        if (drain_beats.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected beat: data %h last %b user %b", out_tdata, out_tlast, out_tuser);
        end else begin
          want = drain_beats[0];
          drain_beats.delete(0);
          beats_checked++;
          if (out_tdata !== want.value || out_tlast !== want.last ||
              out_tuser[0] !== want.error || out_tuser[1] !== want.empty) begin
            mismatches++;
            if (mismatches <= 10)
              $display("beat %0d: expected data %h last %b err %b empty %b, got %h %b %b %b",
                       beats_checked, want.value, want.last, want.error, want.empty,
                       out_tdata, out_tlast, out_tuser[0], out_tuser[1]);
          end
        end
      end
    end
  end

  always @(negedge clk) begin
    command_t c;
    if (rst_n && !(in_tvalid && !in_took)) begin
      if (in_gap > 0) begin
        in_gap--;
        in_tvalid <= 1'b0;
      end else if (idling && in_calm == 0 && $urandom_range(0, 7) == 0) begin
        in_gap = $urandom_range(0, 16);
        in_tvalid <= 1'b0;
      end else if (pending.size() != 0) begin
        if (in_calm > 0) in_calm--;
        else if ($urandom_range(0, 39) == 0) in_calm = $urandom_range(20, 60);
        c = pending[0];
        pending.delete(0);
        in_tvalid <= 1'b1;
        in_tdata  <= c.value;
        in_tuser  <= c.cmd;
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    if (out_gap > 0) begin
      out_gap--;
      out_tready <= 1'b0;
    end else if (idling && out_calm == 0 && $urandom_range(0, 5) == 0) begin
      out_gap = $urandom_range(0, 16);
      out_tready <= 1'b0;
    end else begin
      if (out_calm > 0) out_calm--;
      else if ($urandom_range(0, 39) == 0) out_calm = $urandom_range(20, 60);
      out_tready <= 1'b1;
    end
  end

  task automatic push_cmd(input cmd_t cmd, input logic [15:0] value);
    command_t c;
    c.cmd   = cmd;
    c.value = value;
    pending.insert(pending.size(), c);
    queued_cmds++;
  endtask

  task automatic push_noise();
    cmd_t k;
    k = cmd_t'($urandom_range(0, 2));
    push_cmd(k, 16'($urandom));
  endtask

  task automatic add_session(input session_t kind);
    int live, len, k;
    live = 0;
    case (kind)
      SESS_CLEAN: begin
        len = ($urandom_range(0, 3) == 0) ? $urandom_range(8, 20) : $urandom_range(1, 8);
        for (int i = 0; i < len; i++) begin
          k = $urandom_range(0, 9);
          if (k < 6 || live == 0) begin
            push_cmd(CMD_LOAD, 16'($urandom));
            live++;
          end else if (k < 8) begin
            push_cmd(CMD_REVERSE, 16'($urandom));
          end else begin
            push_cmd(CMD_DISCARD, 16'($urandom));
            live--;
          end
        end
      end
      SESS_UNDERRUN: begin
        live = $urandom_range(0, 3);
        for (int i = 0; i < live; i++) push_cmd(CMD_LOAD, 16'($urandom));
        if ($urandom_range(0, 1) == 1) push_cmd(CMD_REVERSE, 16'($urandom));
        for (int i = 0; i <= live; i++) push_cmd(CMD_DISCARD, 16'($urandom));
        len = $urandom_range(1, 4);
        for (int i = 0; i < len; i++) push_noise();
      end
      SESS_NOISE: begin
        len = $urandom_range(1, 10);
        for (int i = 0; i < len; i++) push_cmd(cmd_t'($urandom_range(0, 3)), 16'($urandom));
      end
      default: begin
        len = SLOTS + $urandom_range(1, 4);
        for (int i = 0; i < len; i++) push_cmd(CMD_LOAD, 16'($urandom));
        k = $urandom_range(3, 12);
        for (int i = 0; i < k; i++) push_cmd(CMD_DISCARD, 16'($urandom));
        for (int i = 0; i < k + 2; i++) push_cmd(CMD_LOAD, 16'($urandom));
        if ($urandom_range(0, 1) == 1) push_cmd(CMD_REVERSE, 16'($urandom));
        push_cmd(CMD_DISCARD, 16'($urandom));
        push_cmd(CMD_DISCARD, 16'($urandom));
      end
    endcase
    push_cmd(CMD_DRAIN, 16'($urandom));
  endtask

  task automatic add_random_session();
    int k;
    k = $urandom_range(0, 19);
    if (k < 13) add_session(SESS_CLEAN);
    else if (k < 16) add_session(SESS_UNDERRUN);
    else if (k < 19) add_session(SESS_NOISE);
    else add_session(SESS_FILL);
  endtask

  task automatic wait_quiet();
    while (accepted_cmds != queued_cmds || drain_beats.size() != 0) @(negedge clk);
  endtask

  initial begin
    int base;
    repeat (7) @(negedge clk);
    rst_n = 1'b1;

    push_cmd(CMD_DRAIN,   16'h1234);
    push_cmd(CMD_LOAD,    16'h0000);
    push_cmd(CMD_LOAD,    16'hFFFF);
    push_cmd(CMD_LOAD,    16'hA5A5);
    push_cmd(CMD_REVERSE, 16'hFFFF);
    push_cmd(CMD_DISCARD, 16'hFFFF);
    push_cmd(CMD_DRAIN,   16'h0000);
    push_cmd(CMD_LOAD,    16'h5A5A);
    push_cmd(CMD_LOAD,    16'h0001);
    push_cmd(CMD_DISCARD, 16'h0000);
    push_cmd(CMD_DRAIN,   16'hFFFF);
    push_cmd(CMD_DISCARD, 16'h0000);
    push_cmd(CMD_LOAD,    16'hBEEF);
    push_cmd(CMD_REVERSE, 16'h0000);
    push_cmd(CMD_DISCARD, 16'h0000);
    push_cmd(CMD_DRAIN,   16'h0000);
    push_cmd(CMD_LOAD,    16'h8000);
    push_cmd(CMD_DISCARD, 16'h7FFF);
    push_cmd(CMD_DRAIN,   16'h0000);
    push_cmd(CMD_LOAD,    16'h7FFF);
    push_cmd(CMD_DRAIN,   16'h0000);
    wait_quiet();

    base = queued_cmds;
    add_session(SESS_FILL);
    while (queued_cmds < base + 205) add_random_session();
    wait_quiet();

    idling = 1'b0;
    while (queued_cmds < base + 240) add_random_session();
    wait_quiet();
    repeat (20) @(negedge clk);
    mismatches += drain_beats.size();

    $display("Accepted %0d commands with %0d drains (%0d on error, %0d on empty),",
             accepted_cmds, drains_seen, error_drains, empty_drains);
    $display("checked %0d result beats; %0d loads hit a full store.",
             beats_checked, dropped_loads);
    if (mismatches == 0) begin
      $display("** reversible_deque_discard_unit: PASSED **");
    end else begin
      $display("** reversible_deque_discard_unit: FAILED **");
    end
    $finish;
  end

  initial begin
    #400000;
    $display("Timed out with %0d beats still expected.", drain_beats.size());
    $display("** reversible_deque_discard_unit: FAILED **");
    $finish;
  end

endmodule
